@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  // parse modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_BODY     = 3'd1;
  localparam logic [2:0] MODE_ESC      = 3'd2;
  localparam logic [2:0] MODE_HEX_HI   = 3'd3;
  localparam logic [2:0] MODE_WANT_BSL = 3'd4;
  localparam logic [2:0] MODE_WANT_U   = 3'd5;
  localparam logic [2:0] MODE_HEX_LO   = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
  localparam logic [3:0] ERR_UNEXP_END   = 4'd2;
  localparam logic [3:0] ERR_CTRL_BYTE   = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd5;
  localparam logic [3:0] ERR_TRUNC_ESC   = 4'd6;
  localparam logic [3:0] ERR_MISSING_LO  = 4'd7;
  localparam logic [3:0] ERR_BAD_LO      = 4'd8;
  localparam logic [3:0] ERR_UNPAIRED_LO = 4'd9;

  localparam int unsigned MaxResults = 4;

  // all results caused by one request; every result of a group shares kind and code
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [2:0]                 cnt;
    logic [1:0]                 kind;
    logic [3:0]                 code;
  } grp_t;

endpackage

@@ rtl/jsu_parser.sv @@
module jsu_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_data_i,
  output jsu_pkg::grp_t    grp_o
);

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] hex_word;
  logic [20:0] pair_cp;

  function automatic jsu_pkg::grp_t one_result(input logic [7:0] b, input logic [1:0] kind,
                                               input logic [3:0] code);
    jsu_pkg::grp_t g;
    g = '0;
    g.data[0] = b;
    g.cnt     = 3'd1;
    g.kind    = kind;
    g.code    = code;
    return g;
  endfunction

  function automatic jsu_pkg::grp_t utf8_group(input logic [20:0] cp);
    jsu_pkg::grp_t g;
    g = '0;
    g.kind = jsu_pkg::KIND_DATA;
    g.code = jsu_pkg::ERR_NONE;
    if (cp <= 21'h00007f) begin
      g.cnt     = 3'd1;
      g.data[0] = cp[7:0];
    end else if (cp <= 21'h0007ff) begin
      g.cnt     = 3'd2;
      g.data[0] = {3'b110, cp[10:6]};
      g.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00ffff) begin
      g.cnt     = 3'd3;
      g.data[0] = {4'b1110, cp[15:12]};
      g.data[1] = {2'b10, cp[11:6]};
      g.data[2] = {2'b10, cp[5:0]};
    end else begin
      g.cnt     = 3'd4;
      g.data[0] = {5'b11110, cp[20:18]};
      g.data[1] = {2'b10, cp[17:12]};
      g.data[2] = {2'b10, cp[11:6]};
      g.data[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_word = {acc_q[11:0], hex_val};
  assign pair_cp  = 21'h010000 + {1'b0, hs_q, hex_word[9:0]};

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    hs_d   = hs_q;
    grp_o  = '0;

    unique case (mode_q)
      jsu_pkg::MODE_IDLE: begin
        if (end_of_data_i) begin
          grp_o = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNEXP_END);
        end else if (in_byte_i == 8'h22) begin
          mode_d = jsu_pkg::MODE_BODY;
        end else begin
          grp_o = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE);
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (end_of_data_i) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNEXP_END);
          mode_d = jsu_pkg::MODE_IDLE;
        end else if (in_byte_i == 8'h22) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
          mode_d = jsu_pkg::MODE_IDLE;
        end else if (in_byte_i < 8'h20) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CTRL_BYTE);
          mode_d = jsu_pkg::MODE_IDLE;
        end else if (in_byte_i == 8'h5c) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          grp_o = one_result(in_byte_i, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
      end
      jsu_pkg::MODE_ESC: begin
        mode_d = jsu_pkg::MODE_BODY;
        if (end_of_data_i) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNEXP_END);
          mode_d = jsu_pkg::MODE_IDLE;
        end else begin
          case (in_byte_i)
            8'h22, 8'h5c, 8'h2f:
              grp_o = one_result(in_byte_i, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h62: grp_o = one_result(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h66: grp_o = one_result(8'h0c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h6e: grp_o = one_result(8'h0a, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h72: grp_o = one_result(8'h0d, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h74: grp_o = one_result(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            8'h75: begin
              mode_d = jsu_pkg::MODE_HEX_HI;
              cnt_d  = 2'd0;
              acc_d  = 16'h0000;
            end
            default: begin
              grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESC);
              mode_d = jsu_pkg::MODE_IDLE;
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
        if (end_of_data_i) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_ESC);
          mode_d = jsu_pkg::MODE_IDLE;
        end else if (!hex_ok) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX);
          mode_d = jsu_pkg::MODE_IDLE;
        end else if (cnt_q != 2'd3) begin
          acc_d = hex_word;
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = 2'd0;
          acc_d = 16'h0000;
          if (mode_q == jsu_pkg::MODE_HEX_HI) begin
            // 6'b110110 marks a high surrogate, 6'b110111 a low one
            if (hex_word[15:10] == 6'b110110) begin
              hs_d   = hex_word[9:0];
              mode_d = jsu_pkg::MODE_WANT_BSL;
            end else if (hex_word[15:10] == 6'b110111) begin
              grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNPAIRED_LO);
              mode_d = jsu_pkg::MODE_IDLE;
            end else begin
              grp_o  = utf8_group({5'd0, hex_word});
              mode_d = jsu_pkg::MODE_BODY;
            end
          end else if (hex_word[15:10] != 6'b110111) begin
            grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_LO);
            mode_d = jsu_pkg::MODE_IDLE;
          end else begin
            grp_o  = utf8_group(pair_cp);
            hs_d   = 10'd0;
            mode_d = jsu_pkg::MODE_BODY;
          end
        end
      end
      jsu_pkg::MODE_WANT_BSL: begin
        if (end_of_data_i || in_byte_i != 8'h5c) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LO);
          mode_d = jsu_pkg::MODE_IDLE;
        end else begin
          mode_d = jsu_pkg::MODE_WANT_U;
        end
      end
      jsu_pkg::MODE_WANT_U: begin
        if (end_of_data_i || in_byte_i != 8'h75) begin
          grp_o  = one_result(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LO);
          mode_d = jsu_pkg::MODE_IDLE;
        end else begin
          mode_d = jsu_pkg::MODE_HEX_LO;
          cnt_d  = 2'd0;
          acc_d  = 16'h0000;
        end
      end
      default: begin
        mode_d = jsu_pkg::MODE_IDLE;
      end
    endcase

    // leaving for idle always drops the escape context
    if (mode_d == jsu_pkg::MODE_IDLE) begin
      cnt_d = 2'd0;
      acc_d = 16'h0000;
      hs_d  = 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      cnt_q  <= 2'd0;
      acc_q  <= 16'h0000;
      hs_q   <= 10'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule

@@ rtl/jsu_emitter.sv @@
module jsu_emitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jsu_pkg::grp_t    grp_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  jsu_pkg::grp_t grp_q, grp_d;
  logic [1:0]    idx_q, idx_d;
  logic          pop, finish, accept;

  assign out_valid_o  = (grp_q.cnt != 3'd0);
  assign out_byte_o   = grp_q.data[idx_q];
  assign kind_o       = grp_q.kind;
  assign error_code_o = grp_q.code;
  assign last_o       = (({1'b0, idx_q} + 3'd1) == grp_q.cnt);

  assign pop        = out_valid_o && !out_stall_i;
  assign finish     = pop && last_o;
  // a new request may load while the last byte of the old group leaves
  assign in_stall_o = out_valid_o && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    grp_d = grp_q;
    idx_d = idx_q;
    if (accept) begin
      grp_d = grp_i;
      idx_d = 2'd0;
    end else if (finish) begin
      grp_d.cnt = 3'd0;
      idx_d     = 2'd0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      idx_q <= 2'd0;
    end else begin
      grp_q <= grp_d;
      idx_q <= idx_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q.cnt <= 3'd4)
    else $error("result group count out of range");

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} < grp_q.cnt))
    else $error("result index past group end");

  a_single_non_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != jsu_pkg::KIND_DATA) |-> (grp_q.cnt == 3'd1 && out_byte_o == 8'h00))
    else $error("close or error result not a lone zero result");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !accept) |=> !out_valid_o)
    else $error("group still valid after its last result left");

  a_step_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_o) |=> (idx_q == $past(idx_q) + 2'd1 && $stable(grp_q.cnt)))
    else $error("group did not advance by one result");

endmodule

@@ rtl/json_string_unescape.sv @@
// the first result of a request is registered and offered in the cycle after the request is taken
// throughput: one request per cycle while each yields at most one result and the output is not stalled
// a request that decodes to k utf-8 bytes holds the output while its k bytes are offered one at a time,
// and the input stalls until the last of them is taken
// reset clears the parse state to idle and empties the output group
module json_string_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [3:0] error_code_o,
  output logic       last_o
);

  jsu_pkg::grp_t grp;
  logic          accept;

  assign accept = in_valid_i && !in_stall_o;

  jsu_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .grp_o         (grp)
  );

  jsu_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .grp_i        (grp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

@@ bench/tb_json_string_unescape.sv @@
`timescale 1ns / 100ps

module tb_json_string_unescape;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int unsigned RANDOM_REQUESTS = 420;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_ONE} row_check_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    row_check_e chk;
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] code;
  } stim_row_t;

  // surrogate pairing and its faults, but for an unpaired low surrogate, come from the random strings
  localparam stim_row_t DIRECTED [30] = '{
    '{8'h41, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE},
    '{8'hff, 1'b1, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNEXP_END},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h00, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CTRL_BYTE},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'hff, 1'b0, CHK_ONE,     8'hff, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h20, 1'b0, CHK_ONE,     8'h20, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h5c, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h6e, 1'b0, CHK_PREDICT, 8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h5c, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h71, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESC},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h5c, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h75, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h67, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h5c, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h75, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h34, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h00, 1'b1, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_ESC},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h5c, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h75, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h44, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h63, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h30, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h30, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNPAIRED_LO},
    '{8'h22, 1'b0, CHK_SILENT,  8'h00, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h7f, 1'b0, CHK_ONE,     8'h7f, jsu_pkg::KIND_DATA,  jsu_pkg::ERR_NONE},
    '{8'h22, 1'b0, CHK_ONE,     8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE}
  };

  localparam logic [7:0] ESC_LETTERS [8] = '{
    8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74
  };

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [3:0] error_code_o;
  logic       last_o;

  json_string_unescape dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  // predictor state
  logic [2:0]  mode_q;
  logic [1:0]  nibbles_q;
  logic [15:0] hex_q;
  logic [9:0]  hi_bits_q;
  result_t     step_results[$];
  result_t     pending_decodes[$];

  logic [8:0]  text_q[$];
  idle_mode_e  idle_mode    = IDLE_NONE;
  int          holdoff_left = 0;
  int          failures     = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("json_string_unescape regression: fail");
    $finish;
  end

  function automatic void clear_parser();
    mode_q    = jsu_pkg::MODE_IDLE;
    nibbles_q = 2'd0;
    hex_q     = 16'h0000;
    hi_bits_q = 10'h000;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic [1:0] k,
                                     input logic [3:0] c);
    result_t r;
    r = '{data: b, kind: k, code: c, last: 1'b0};
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void raise_fault(input logic [3:0] c);
    clear_parser();
    add_result(8'h00, jsu_pkg::KIND_ERROR, c);
  endfunction

  // bit 4 set marks a valid hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
    return 5'h00;
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_result(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp <= 21'h7ff) begin
      add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp <= 21'hffff) begin
      add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else begin
      add_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end
  endfunction

  function automatic void predict_unescape(input logic [7:0] b, input logic eod);
    logic [4:0]  nib;
    logic [15:0] v;
    logic [7:0]  ch;
    logic        known;
    result_t     r;
    step_results.delete();
    case (mode_q)
      jsu_pkg::MODE_IDLE: begin
        if (eod) raise_fault(jsu_pkg::ERR_UNEXP_END);
        else if (b == CH_QUOTE) mode_q = jsu_pkg::MODE_BODY;
        else raise_fault(jsu_pkg::ERR_NO_QUOTE);
      end
      jsu_pkg::MODE_BODY: begin
        if (eod) begin
          raise_fault(jsu_pkg::ERR_UNEXP_END);
        end else if (b == CH_QUOTE) begin
          clear_parser();
          add_result(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
        end else if (b < 8'h20) begin
          raise_fault(jsu_pkg::ERR_CTRL_BYTE);
        end else if (b == CH_BSLASH) begin
          mode_q = jsu_pkg::MODE_ESC;
        end else begin
          add_result(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (eod) begin
          raise_fault(jsu_pkg::ERR_UNEXP_END);
        end else if (b == CH_U) begin
          mode_q    = jsu_pkg::MODE_HEX_HI;
          nibbles_q = 2'd0;
          hex_q     = 16'h0000;
        end else begin
          known = 1'b1;
          ch    = b;
          case (b)
            8'h22, 8'h5c, 8'h2f: ch = b;
            8'h62: ch = 8'h08;
            8'h66: ch = 8'h0c;
            8'h6e: ch = 8'h0a;
            8'h72: ch = 8'h0d;
            8'h74: ch = 8'h09;
            default: known = 1'b0;
          endcase
          if (known) begin
            mode_q = jsu_pkg::MODE_BODY;
            add_result(ch, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
          end else begin
            raise_fault(jsu_pkg::ERR_BAD_ESC);
          end
        end
      end
      jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
        nib = hex_nibble(b);
        if (eod) begin
          raise_fault(jsu_pkg::ERR_TRUNC_ESC);
        end else if (!nib[4]) begin
          raise_fault(jsu_pkg::ERR_BAD_HEX);
        end else begin
          v = {hex_q[11:0], nib[3:0]};
          if (nibbles_q != 2'd3) begin
            hex_q     = v;
            nibbles_q = nibbles_q + 2'd1;
          end else begin
            nibbles_q = 2'd0;
            hex_q     = 16'h0000;
            if (mode_q == jsu_pkg::MODE_HEX_HI) begin
              if (v >= 16'hd800 && v <= 16'hdbff) begin
                hi_bits_q = v[9:0];
                mode_q    = jsu_pkg::MODE_WANT_BSL;
              end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
                raise_fault(jsu_pkg::ERR_UNPAIRED_LO);
              end else begin
                mode_q = jsu_pkg::MODE_BODY;
                emit_code_point({5'd0, v});
              end
            end else if (v < 16'hdc00 || v > 16'hdfff) begin
              raise_fault(jsu_pkg::ERR_BAD_LO);
            end else begin
              mode_q = jsu_pkg::MODE_BODY;
              emit_code_point(21'h10000 + {1'b0, hi_bits_q, v[9:0]});
              hi_bits_q = 10'h000;
            end
          end
        end
      end
      jsu_pkg::MODE_WANT_BSL: begin
        if (eod || b != CH_BSLASH) raise_fault(jsu_pkg::ERR_MISSING_LO);
        else mode_q = jsu_pkg::MODE_WANT_U;
      end
      jsu_pkg::MODE_WANT_U: begin
        if (eod || b != CH_U) begin
          raise_fault(jsu_pkg::ERR_MISSING_LO);
        end else begin
          mode_q    = jsu_pkg::MODE_HEX_LO;
          nibbles_q = 2'd0;
          hex_q     = 16'h0000;
        end
      end
      default: clear_parser();
    endcase
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.insert(step_results.size(), r);
    end
  endfunction

  function automatic logic roll_idle(input logic enabled_85, input logic enabled_21);
    if (enabled_85) return $urandom_range(99) < 85;
    if (enabled_21) return $urandom_range(99) < 21;
    return 1'b0;
  endfunction

  // receiver side, with its own count for the long hold-off
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall_i <= roll_idle(idle_mode == IDLE_RECEIVER, idle_mode == IDLE_BOTH);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decodes.size() == 0) begin
        failures++;
        $error("result with nothing pending: out_byte %h kind %0d error_code %0d",
               out_byte_o, kind_o, error_code_o);
      end else begin
        want = pending_decodes.pop_front();
        if (out_byte_o !== want.data) begin
          failures++;
          $error("out_byte: expected %h, got %h", want.data, out_byte_o);
        end
        if (kind_o !== want.kind) begin
          failures++;
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
        end
        if (error_code_o !== want.code) begin
          failures++;
          $error("error_code: expected %0d, got %0d", want.code, error_code_o);
        end
        if (last_o !== want.last) begin
          failures++;
          $error("last: expected %0d, got %0d", want.last, last_o);
        end
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eod);
    int gap;
    gap = 0;
    while (roll_idle(idle_mode == IDLE_SENDER, idle_mode == IDLE_BOTH)) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_data_i <= eod;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_unescape(b, eod);
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic eod);
    send_request(b, eod);
    foreach (step_results[i]) pending_decodes.insert(pending_decodes.size(), step_results[i]);
  endtask

  // always waits on the clock before it checks the queue, so valid is never lowered and raised in one step
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_decodes.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void put_char(input logic [7:0] b);
    text_q.insert(text_q.size(), {1'b0, b});
  endfunction

  function automatic void put_u_escape(input logic [15:0] v);
    put_char(CH_BSLASH);
    put_char(CH_U);
    put_char(hex_char(v[15:12]));
    put_char(hex_char(v[11:8]));
    put_char(hex_char(v[7:4]));
    put_char(hex_char(v[3:0]));
  endfunction

  // mostly well-formed strings with random content, some broken or noise
  function automatic void build_string();
    int          nseg;
    int          idx;
    int          pick;
    logic [7:0]  b;
    logic [15:0] cp;
    text_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6))
        text_q.insert(text_q.size(),
                      {1'($urandom_range(99) < 15), 8'($urandom_range(255))});
      return;
    end
    put_char(CH_QUOTE);
    nseg = $urandom_range(0, 6);
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          do b = 8'($urandom_range(8'h20, 8'hff)); while (b == CH_QUOTE || b == CH_BSLASH);
          put_char(b);
        end
        3: begin
          put_char(CH_BSLASH);
          put_char(ESC_LETTERS[$urandom_range(0, 7)]);
        end
        4: put_u_escape(16'($urandom_range(16'h0000, 16'h007f)));
        5: put_u_escape(16'($urandom_range(16'h0080, 16'h07ff)));
        6: begin
          cp = 16'($urandom_range(16'h0800, 16'hf7ff));
          if (cp >= 16'hd800) cp = cp + 16'h0800;
          put_u_escape(cp);
        end
        7, 8: begin
          put_u_escape(16'hd800 + 16'($urandom_range(0, 1023)));
          put_u_escape(16'hdc00 + 16'($urandom_range(0, 1023)));
        end
        default: begin
          pick = $urandom_range(0, 3);
          if (pick == 3) begin
            put_u_escape(16'hdc00 + 16'($urandom_range(0, 1023)));
          end else begin
            put_u_escape(16'hd800 + 16'($urandom_range(0, 1023)));
            if (pick == 0) begin
              put_char(8'h78);
            end else if (pick == 1) begin
              put_char(CH_BSLASH);
              put_char(8'h6e);
            end else begin
              cp = 16'($urandom_range(0, 16'hdbff));
              if ($urandom_range(1)) cp = 16'he000 + 16'($urandom_range(0, 16'h1fff));
              put_u_escape(cp);
            end
          end
        end
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 80) begin
      put_char(CH_QUOTE);
    end else if (pick < 88) begin
      idx = $urandom_range(1, text_q.size());
      while (text_q.size() > idx) void'(text_q.pop_back());
      text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(255))});
    end else begin
      idx = $urandom_range(0, text_q.size() - 1);
      text_q[idx] = {1'b0, 8'($urandom_range(255))};
      put_char(CH_QUOTE);
    end
  endfunction

  initial begin
    int   random_sent;
    logic held;
    logic paused;
    result_t typed;
    random_sent = 0;
    held        = 1'b0;
    paused      = 1'b0;
    clear_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].b, DIRECTED[i].eod);
      case (DIRECTED[i].chk)
        CHK_PREDICT: foreach (step_results[k])
          pending_decodes.insert(pending_decodes.size(), step_results[k]);
        CHK_ONE: begin
          typed = '{data: DIRECTED[i].data, kind: DIRECTED[i].kind,
                    code: DIRECTED[i].code, last: 1'b1};
          pending_decodes.insert(pending_decodes.size(), typed);
        end
        default: ;
      endcase
    end

    while (random_sent < RANDOM_REQUESTS) begin
      idle_mode = idle_mode_e'((random_sent / 60) % 4);
      // receiver holds off while requests keep coming, so the input backs up
      if (!held && random_sent >= 250) begin
        held         = 1'b1;
        holdoff_left = 150;
      end
      if (!paused && random_sent >= 380) begin
        paused = 1'b1;
        wait_drained();
      end
      build_string();
      foreach (text_q[k]) begin
        send_predicted(text_q[k][7:0], text_q[k][8]);
        random_sent++;
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (failures == 0) begin
      $display("json_string_unescape regression: pass");
    end else begin
      $display("json_string_unescape regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/jsu_pkg.sv
rtl/jsu_parser.sv
rtl/jsu_emitter.sv
rtl/json_string_unescape.sv
bench/tb_json_string_unescape.sv
